>>> hdl/cdq_pkg.sv
// Package for the character deque core: sizes, operation and status codes,
// payload structs and the control struct broadcast to the cell row.
// No dependencies.
`timescale 1ns / 1ps

package cdq_pkg;

    localparam int DEPTH     = 32;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CHAR_W    = 8;
    localparam int ENTRIES_W = 6;

    typedef logic [CNT_W-1:0] t_cnt;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_INSERT     = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_POP_BACK   = 3'd4,
        OP_PALINDROME = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_op                      func;
        logic signed [CHAR_W-1:0] char_value;
    } t_in_item;

    typedef struct packed {
        t_status                  status;
        logic signed [CHAR_W-1:0] char_out;
        logic                     is_palindrome;
        logic [ENTRIES_W-1:0]     entries_held;
    } t_out_item;

    typedef enum logic [1:0] {
        CM_HOLD,
        CM_INSERT,
        CM_SHIFT_LEFT
    } t_cell_mode;

    typedef struct packed {
        t_cell_mode               mode;
        logic                     ins_back;
        logic                     ins_cmp;
        logic signed [CHAR_W-1:0] value;
        logic                     sh_load;
        logic                     sh_shift;
    } t_cell_ctl;

    typedef enum logic {
        S_IDLE,
        S_PAL
    } t_state;

endpackage

>>> hdl/char_deque_sorted_insert_palindrome_core.sv
// Top level of the character deque: control, count and output register
// around a row of cdq_cell instances. Depends on cdq_pkg and cdq_cell.
`timescale 1ns / 1ps

// Pushes, ordered insert and pops finish in the cycle of the transfer; the result stands
// in the output register in the cycle after, one transfer a cycle while the receiver keeps up.
// The palindrome test copies the row into shadow registers, then shifts the
// shadow row one place a cycle, checking one front/back pair each cycle; no transfer is
// taken until the scan stops and the output register is free to take the result.
// Reset (synchronous, active low) empties the deque and the output register.
module char_deque_sorted_insert_palindrome_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  cdq_pkg::t_in_item i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output cdq_pkg::t_out_item o_out_item
);
    import cdq_pkg::*;

    // Control state
    t_state    r_state;
    t_state    n_state;
    t_cnt      r_count;
    t_cnt      n_count;
    t_cnt      r_scount;
    t_cnt      n_scount;
    logic      r_out_valid;
    logic      n_out_valid;
    t_out_item r_out_item;
    t_out_item n_out_item;

    // Cell row wiring
    t_cell_ctl                w_ctl;
    logic                     w_valid  [DEPTH+1];
    logic                     w_svalid [DEPTH+1];
    logic                     w_pass   [DEPTH+1];
    logic signed [CHAR_W-1:0] w_data   [DEPTH];
    logic signed [CHAR_W-1:0] w_shadow [DEPTH];
    logic signed [CHAR_W-1:0] w_last   [DEPTH];
    logic signed [CHAR_W-1:0] w_back   [DEPTH];
    logic signed [CHAR_W-1:0] w_last_char;
    logic signed [CHAR_W-1:0] w_back_char;

    logic    w_accept;
    logic    w_out_free;
    logic    w_full;
    logic    w_empty;
    logic    w_pal_done;
    logic    w_pal_fin;
    logic    w_sh_shift;
    t_status w_status;
    logic signed [CHAR_W-1:0] w_char;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_empty    = (r_count == '0);

    // Thermometer of occupied cells and of live shadow cells.
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_valid
            assign w_valid[gi]  = (CNT_W'(gi) < r_count);
            assign w_svalid[gi] = (CNT_W'(gi) < r_scount);
        end
    endgenerate
    assign w_valid[DEPTH]  = 1'b0;
    assign w_svalid[DEPTH] = 1'b0;
    assign w_pass[0]       = 1'b1;

    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            cdq_cell u_cell (
                .i_clk            (i_clk),
                .i_ctl            (w_ctl),
                .i_valid          (w_valid[gi]),
                .i_right_valid    (w_valid[gi+1]),
                .i_pass           (w_pass[gi]),
                .i_left_data      ((gi == 0) ? w_ctl.value : w_data[(gi == 0) ? 0 : gi-1]),
                .i_right_data     (w_data[(gi == DEPTH-1) ? gi : gi+1]),
                .i_sh_valid       (w_svalid[gi]),
                .i_sh_right_valid (w_svalid[gi+1]),
                .i_right_shadow   (w_shadow[(gi == DEPTH-1) ? gi : gi+1]),
                .o_pass           (w_pass[gi+1]),
                .o_data           (w_data[gi]),
                .o_shadow         (w_shadow[gi]),
                .o_last_term      (w_last[gi]),
                .o_back_term      (w_back[gi])
            );
        end
    endgenerate

    // At most one cell flags itself as last (none when empty): merge the one-hot terms.
    always_comb begin
        w_last_char = '0;
        w_back_char = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_last_char = w_last_char | w_last[k];
            w_back_char = w_back_char | w_back[k];
        end
    end

    // Palindrome scan: stop on a mismatch or when fewer than two remain.
    assign w_pal_done = (r_scount < CNT_W'(2)) || (w_shadow[0] != w_back_char);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_in_item.func == OP_PALINDROME)) begin
                    n_state = S_PAL;
                end
            end
            S_PAL: begin
                if (w_pal_fin) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_pal_fin  = 1'b0;
        w_sh_shift = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = w_out_free;
            end
            S_PAL: begin
                w_pal_fin  = w_pal_done && w_out_free;
                w_sh_shift = !w_pal_done;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // Decode the transferred operation into cell control and a result.
    always_comb begin
        w_ctl          = '0;
        w_ctl.mode     = CM_HOLD;
        w_ctl.value    = i_in_item.char_value;
        w_ctl.sh_shift = w_sh_shift;
        w_status       = ST_OK;
        w_char         = '0;
        n_count        = r_count;
        n_scount       = r_scount;
        if (w_sh_shift) begin
            n_scount = r_scount - CNT_W'(2);
        end
        if (w_accept) begin
            case (i_in_item.func)
                OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
                    if (w_full) begin
                        w_status = ST_FULL;
                    end else begin
                        w_ctl.mode     = CM_INSERT;
                        w_ctl.ins_back = (i_in_item.func == OP_PUSH_BACK);
                        w_ctl.ins_cmp  = (i_in_item.func == OP_INSERT);
                        n_count        = r_count + CNT_W'(1);
                    end
                end
                OP_POP_FRONT: begin
                    if (w_empty) begin
                        w_status = ST_EMPTY;
                    end else begin
                        w_ctl.mode = CM_SHIFT_LEFT;
                        w_char     = w_data[0];
                        n_count    = r_count - CNT_W'(1);
                    end
                end
                OP_POP_BACK: begin
                    if (w_empty) begin
                        w_status = ST_EMPTY;
                    end else begin
                        w_char  = w_last_char;
                        n_count = r_count - CNT_W'(1);
                    end
                end
                OP_PALINDROME: begin
                    w_ctl.sh_load = 1'b1;
                    n_scount      = r_count;
                end
                default: begin
                    w_status = ST_OK;
                end
            endcase
        end
    end

    // Output register: load on a finished item, drop valid once taken.
    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_item  = r_out_item;
        if (w_accept && (i_in_item.func != OP_PALINDROME)) begin
            n_out_valid               = 1'b1;
            n_out_item.status         = w_status;
            n_out_item.char_out       = w_char;
            n_out_item.is_palindrome  = 1'b0;
            n_out_item.entries_held   = ENTRIES_W'(n_count);
        end else if (w_pal_fin) begin
            n_out_valid               = 1'b1;
            n_out_item.status         = ST_OK;
            n_out_item.char_out       = '0;
            n_out_item.is_palindrome  = (r_scount < CNT_W'(2));
            n_out_item.entries_held   = ENTRIES_W'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_scount    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_scount    <= n_scount;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> hdl/cdq_cell.sv
// One cell of the deque row: holds one character and one shadow copy.
// Depends on cdq_pkg.
`timescale 1ns / 1ps

module cdq_cell (
    input  logic                              i_clk,
    input  cdq_pkg::t_cell_ctl                i_ctl,
    input  logic                              i_valid,
    input  logic                              i_right_valid,
    input  logic                              i_pass,
    input  logic signed [cdq_pkg::CHAR_W-1:0] i_left_data,
    input  logic signed [cdq_pkg::CHAR_W-1:0] i_right_data,
    input  logic                              i_sh_valid,
    input  logic                              i_sh_right_valid,
    input  logic signed [cdq_pkg::CHAR_W-1:0] i_right_shadow,
    output logic                              o_pass,
    output logic signed [cdq_pkg::CHAR_W-1:0] o_data,
    output logic signed [cdq_pkg::CHAR_W-1:0] o_shadow,
    output logic signed [cdq_pkg::CHAR_W-1:0] o_last_term,
    output logic signed [cdq_pkg::CHAR_W-1:0] o_back_term
);
    import cdq_pkg::*;

    logic signed [CHAR_W-1:0] r_data;
    logic signed [CHAR_W-1:0] n_data;
    logic signed [CHAR_W-1:0] r_shadow;
    logic signed [CHAR_W-1:0] n_shadow;
    logic                     w_gt;

    // New value goes behind this entry when it is smaller (or forced at the back).
    assign w_gt   = i_valid && (i_ctl.ins_back || (i_ctl.ins_cmp && (i_ctl.value < r_data)));
    assign o_pass = i_pass && w_gt;

    always_comb begin
        n_data = r_data;
        case (i_ctl.mode)
            CM_INSERT: begin
                if (!i_pass) begin
                    n_data = i_left_data;
                end else if (!w_gt) begin
                    n_data = i_ctl.value;
                end
            end
            CM_SHIFT_LEFT: begin
                n_data = i_right_data;
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_comb begin
        n_shadow = r_shadow;
        if (i_ctl.sh_load) begin
            n_shadow = r_data;
        end else if (i_ctl.sh_shift) begin
            n_shadow = i_right_shadow;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data   <= n_data;
        r_shadow <= n_shadow;
    end

    assign o_data      = r_data;
    assign o_shadow    = r_shadow;
    assign o_last_term = (i_valid && !i_right_valid) ? r_data : '0;
    assign o_back_term = (i_sh_valid && !i_sh_right_valid) ? r_shadow : '0;

endmodule
